// ----- design/first_fit_bin_packer_macros.svh -----
`ifndef FIRST_FIT_BIN_PACKER_MACROS_SVH
`define FIRST_FIT_BIN_PACKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define FFBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FFBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ffbp_pkg.sv -----
package ffbp_pkg;

    localparam int MAX_BINS    = 1024;
    localparam int WEIGHT_BITS = 20;
    localparam int IDX_W       = $clog2(MAX_BINS);
    localparam int CNT_W       = $clog2(MAX_BINS + 1);
    localparam int SUM_W       = 50;
    localparam int CFG_IDX_W   = 1;

    localparam logic [WEIGHT_BITS-1:0] CAP_RESET = WEIGHT_BITS'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_BIN_CAPACITY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ITEM_WEIGHT = 1'd1;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_TABLE_FULL = 2'd1;
    localparam logic [1:0] ERR_OVERSIZE   = 2'd2;

    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef logic [SUM_W-1:0]       sum_t;

    typedef struct packed {
        logic start;
        logic push;
    } sq_ctrl_t;

endpackage

// ----- design/ffbp_ram.sv -----
module ffbp_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/ffbp_sqacc.sv -----
module ffbp_sqacc import ffbp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  sq_ctrl_t ctl,
    input  sum_t     init,
    input  weight_t  data,
    output sum_t     acc,
    output logic     busy
);

    localparam int PROD_W = 2 * WEIGHT_BITS;

    weight_t            d1_reg;
    logic               v1_reg, v2_reg;
    logic [PROD_W-1:0]  prod_reg;
    sum_t               acc_reg, acc_next;

    always_comb begin
        acc_next = acc_reg;
        if (ctl.start) begin
            acc_next = init;
        end else if (v2_reg) begin
            acc_next = acc_reg + SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.push;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        d1_reg   <= data;
        prod_reg <= PROD_W'(d1_reg) * PROD_W'(d1_reg);
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = v1_reg || v2_reg;

endmodule

// ----- design/first_fit_bin_packer.sv -----
// path: an oversized item goes from evaluation straight to the result, or to the square sum
// when last; a forced or directly opened item passes through the new-bin state; a scan reads
// the bins in order from the first open one, goes on to a new bin when none fits, and waits
// on the square accumulator when a bin retires. A last item then adds the squares of the bins
// from the first open one up to the bin count to the retired square sum.
// throughput: one request at a time, the next is taken from the cycle its result turns valid.
// reset: bin count, first-open index, peak and retired square sum clear; capacity returns to
// 1000; volume memory is not cleared and needs no clearing pass.
module first_fit_bin_packer import ffbp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  weight_t              cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  weight_t              s_item_weight,
    input  logic                 s_force_new_bin,
    input  logic                 s_last_item,
    input  logic                 s_clear_bins,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_bin_index,
    output logic                 m_opened_bin,
    output logic [1:0]           m_error_code,
    output count_t               m_bins_used,
    output sum_t                 m_fill_square_sum,
    output weight_t              m_largest_bin_volume,
    output logic                 m_totals_valid
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EVAL     = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_NEW      = 3'd3;
    localparam logic [2:0] ST_RETIRE   = 3'd4;
    localparam logic [2:0] ST_SUM_INIT = 3'd5;
    localparam logic [2:0] ST_SUM_RUN  = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    logic [2:0] state_reg, state_next;
    weight_t    cap_reg, cap_next, minw_reg, minw_next;
    weight_t    least_reg, least_next, peak_reg, peak_next;
    count_t     count_reg, count_next, fo_reg, fo_next;
    count_t     ptr_reg, ptr_next, chk_reg, chk_next;
    logic       pend_reg, pend_next;
    sum_t       retired_reg, retired_next;

    weight_t    w_reg, w_next;
    logic       forced_reg, forced_next, last_reg, last_next;

    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic             ropen_reg, ropen_next;
    logic [1:0]       rerr_reg, rerr_next;
    sum_t             rsum_reg, rsum_next;

    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_open_reg, out_tot_reg;
    logic [1:0]       out_err_reg;
    count_t           out_cnt_reg;
    sum_t             out_sum_reg;
    weight_t          out_peak_reg;
    logic             out_load;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    weight_t          mem_wdata, mem_rdata;

    sq_ctrl_t sq_ctl;
    sum_t     sq_init, sq_acc;
    weight_t  sq_data;
    logic     sq_busy;

    logic             cfg_we, in_acc, too_big, room_least, fits, retire_hit;
    logic             table_full, more, out_free;
    weight_t          cap_now, vol_new;
    count_t           fo_eff;
    logic [WEIGHT_BITS:0] least_sum, vol_sum, retire_sum;
    logic [2:0]       after_place;

    ffbp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_BINS)
    ) u_volume_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffbp_sqacc u_sqacc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (sq_ctl),
        .init    (sq_init),
        .data    (sq_data),
        .acc     (sq_acc),
        .busy    (sq_busy)
    );

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cap_now   = (cfg_we && cfg_addr == REG_BIN_CAPACITY) ? cfg_wdata : cap_reg;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;

    assign fo_eff      = (fo_reg > count_reg) ? count_reg : fo_reg;
    assign too_big     = w_reg > cap_reg;
    assign least_sum   = {1'b0, w_reg} + {1'b0, least_reg};
    assign room_least  = least_sum <= {1'b0, cap_reg};
    assign vol_sum     = {1'b0, mem_rdata} + {1'b0, w_reg};
    assign fits        = vol_sum <= {1'b0, cap_reg};
    assign vol_new     = vol_sum[WEIGHT_BITS-1:0];
    assign retire_sum  = {1'b0, vol_new} + {1'b0, minw_reg};
    assign retire_hit  = !last_reg && (chk_reg == fo_reg) && (retire_sum > {1'b0, cap_reg});
    assign table_full  = count_reg >= CNT_W'(MAX_BINS);
    assign more        = ptr_reg < count_reg;
    assign out_free    = !m_valid_reg || m_ready;
    assign after_place = last_reg ? ST_SUM_INIT : ST_FINISH;
    assign mem_raddr   = ptr_reg[IDX_W-1:0];

    always_comb begin
        state_next   = state_reg;
        cap_next     = cap_now;
        minw_next    = (cfg_we && cfg_addr == REG_MIN_ITEM_WEIGHT) ? cfg_wdata : minw_reg;
        least_next   = least_reg;
        peak_next    = peak_reg;
        count_next   = count_reg;
        fo_next      = fo_reg;
        ptr_next     = ptr_reg;
        chk_next     = chk_reg;
        pend_next    = pend_reg;
        retired_next = retired_reg;
        w_next       = w_reg;
        forced_next  = forced_reg;
        last_next    = last_reg;
        ridx_next    = ridx_reg;
        ropen_next   = ropen_reg;
        rerr_next    = rerr_reg;
        rsum_next    = rsum_reg;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = chk_reg[IDX_W-1:0];
        mem_wdata    = vol_new;
        sq_ctl       = '0;
        sq_init      = retired_reg;
        sq_data      = mem_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    w_next      = s_item_weight;
                    forced_next = s_force_new_bin;
                    last_next   = s_last_item;
                    ridx_next   = '0;
                    ropen_next  = 1'b0;
                    rerr_next   = ERR_NONE;
                    rsum_next   = '0;
                    if (s_clear_bins) begin
                        count_next   = '0;
                        fo_next      = '0;
                        least_next   = cap_now;
                        peak_next    = '0;
                        retired_next = '0;
                    end
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                fo_next = fo_eff;
                if (too_big) begin
                    rerr_next  = ERR_OVERSIZE;
                    state_next = after_place;
                end else if (!forced_reg && (last_reg || room_least) && fo_eff < count_reg) begin
                    ptr_next   = fo_eff;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_NEW;
                end
            end
            ST_SCAN: begin
                if (more) begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                pend_next = more;
                chk_next  = ptr_reg;
                if (pend_reg) begin
                    if (fits) begin
                        mem_we    = 1'b1;
                        ridx_next = chk_reg[IDX_W-1:0];
                        pend_next = 1'b0;
                        if (vol_new > peak_reg) begin
                            peak_next = vol_new;
                        end
                        if (retire_hit) begin
                            fo_next       = fo_reg + CNT_W'(1);
                            sq_ctl.start  = 1'b1;
                            sq_ctl.push   = 1'b1;
                            sq_data       = vol_new;
                            state_next    = ST_RETIRE;
                        end else begin
                            state_next = after_place;
                        end
                    end else if (!more) begin
                        pend_next  = 1'b0;
                        state_next = ST_NEW;
                    end
                end
            end
            ST_NEW: begin
                if (table_full) begin
                    rerr_next = ERR_TABLE_FULL;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = count_reg[IDX_W-1:0];
                    mem_wdata  = w_reg;
                    ridx_next  = count_reg[IDX_W-1:0];
                    ropen_next = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (w_reg < least_reg) begin
                        least_next = w_reg;
                    end
                    if (w_reg > peak_reg) begin
                        peak_next = w_reg;
                    end
                end
                state_next = after_place;
            end
            ST_RETIRE: begin
                if (!sq_busy) begin
                    retired_next = sq_acc;
                    state_next   = ST_FINISH;
                end
            end
            ST_SUM_INIT: begin
                sq_ctl.start = 1'b1;
                ptr_next     = fo_reg;
                pend_next    = 1'b0;
                state_next   = ST_SUM_RUN;
            end
            ST_SUM_RUN: begin
                if (more) begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                pend_next   = more;
                sq_ctl.push = pend_reg;
                if (!more && !pend_reg && !sq_busy) begin
                    rsum_next  = sq_acc;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            minw_reg    <= '0;
            least_reg   <= CAP_RESET;
            peak_reg    <= '0;
            count_reg   <= '0;
            fo_reg      <= '0;
            pend_reg    <= 1'b0;
            retired_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            minw_reg    <= minw_next;
            least_reg   <= least_next;
            peak_reg    <= peak_next;
            count_reg   <= count_next;
            fo_reg      <= fo_next;
            pend_reg    <= pend_next;
            retired_reg <= retired_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg      <= w_next;
        forced_reg <= forced_next;
        last_reg   <= last_next;
        ptr_reg    <= ptr_next;
        chk_reg    <= chk_next;
        ridx_reg   <= ridx_next;
        ropen_reg  <= ropen_next;
        rerr_reg   <= rerr_next;
        rsum_reg   <= rsum_next;
        if (out_load) begin
            out_idx_reg  <= ridx_reg;
            out_open_reg <= ropen_reg;
            out_err_reg  <= rerr_reg;
            out_cnt_reg  <= count_reg;
            out_sum_reg  <= rsum_reg;
            out_peak_reg <= peak_reg;
            out_tot_reg  <= last_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_bin_index          = out_idx_reg;
    assign m_opened_bin         = out_open_reg;
    assign m_error_code         = out_err_reg;
    assign m_bins_used          = out_cnt_reg;
    assign m_fill_square_sum    = out_sum_reg;
    assign m_largest_bin_volume = out_peak_reg;
    assign m_totals_valid       = out_tot_reg;

endmodule

// ----- design/ffbp_checker.sv -----
`include "first_fit_bin_packer_macros.svh"

module ffbp_checker import ffbp_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [IDX_W-1:0] m_bin_index,
    input logic             m_opened_bin,
    input logic [1:0]       m_error_code,
    input count_t           m_bins_used,
    input sum_t             m_fill_square_sum,
    input weight_t          m_largest_bin_volume,
    input logic             m_totals_valid
);

    `FFBP_ASSERT_NOW(a_err_drops, m_valid && m_error_code != ERR_NONE, !m_opened_bin && m_bin_index == '0, "dropped request shows a placement")
    `FFBP_ASSERT_NOW(a_open_last, m_valid && m_opened_bin, m_bin_index == IDX_W'(m_bins_used - CNT_W'(1)), "new bin is not the last bin")
    `FFBP_ASSERT_NOW(a_sum_gated, m_valid && !m_totals_valid, m_fill_square_sum == '0, "square sum without totals")
    `FFBP_ASSERT_NOW(a_err_code, m_valid, m_error_code == ERR_NONE || m_error_code == ERR_TABLE_FULL || m_error_code == ERR_OVERSIZE, "unknown error code")
    `FFBP_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_bin_index) && $stable(m_bins_used) && $stable(m_largest_bin_volume), "result changed while stalled")

endmodule

bind first_fit_bin_packer ffbp_checker u_ffbp_checker (.*);

// ----- tb/first_fit_bin_packer_test.sv -----
module first_fit_bin_packer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ffbp_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic             opened_bin;
        logic [1:0]       error_code;
        count_t           bins_used;
        sum_t             fill_square_sum;
        weight_t          largest_bin_volume;
        logic             totals_valid;
    } placement_t;

    localparam weight_t WEIGHT_MAX = '1;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr = REG_BIN_CAPACITY;
    weight_t              cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    weight_t              s_item_weight = '0;
    logic                 s_force_new_bin = 1'b0;
    logic                 s_last_item = 1'b0;
    logic                 s_clear_bins = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [IDX_W-1:0]     m_bin_index;
    logic                 m_opened_bin;
    logic [1:0]           m_error_code;
    count_t               m_bins_used;
    sum_t                 m_fill_square_sum;
    weight_t              m_largest_bin_volume;
    logic                 m_totals_valid;

    // packer state as predicted from the requests
    weight_t     capacity;
    weight_t     min_weight;
    weight_t     bin_fill [MAX_BINS];
    int unsigned bins_open;
    int unsigned first_live;
    weight_t     least_opening;
    weight_t     peak_fill;
    sum_t        retired_sum;

    placement_t  placements_due[$];
    placement_t  due;
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_opened = 0;
    int unsigned n_dropped = 0;
    int unsigned n_totals = 0;
    int unsigned n_settings = 0;

    first_fit_bin_packer DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_item_weight        (s_item_weight),
        .s_force_new_bin      (s_force_new_bin),
        .s_last_item          (s_last_item),
        .s_clear_bins         (s_clear_bins),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_bin_index          (m_bin_index),
        .m_opened_bin         (m_opened_bin),
        .m_error_code         (m_error_code),
        .m_bins_used          (m_bins_used),
        .m_fill_square_sum    (m_fill_square_sum),
        .m_largest_bin_volume (m_largest_bin_volume),
        .m_totals_valid       (m_totals_valid)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("first_fit_bin_packer test failed");
        $finish;
    end

    function automatic sum_t fill_square(weight_t v);
        longint unsigned x;
        x = v;
        return sum_t'(x * x);
    endfunction

    function automatic void empty_bins();
        bins_open     = 0;
        first_live    = 0;
        least_opening = capacity;
        peak_fill     = '0;
        retired_sum   = '0;
    endfunction

    function automatic sum_t square_total();
        sum_t s;
        s = retired_sum;
        for (int unsigned i = first_live; i < bins_open; i++) begin
            s += fill_square(bin_fill[i]);
        end
        return s;
    endfunction

    function automatic placement_t place_item(weight_t w, logic forced, logic last,
                                              logic clear);
        placement_t      r;
        logic            need_new;
        longint unsigned cap;
        longint unsigned wl;
        longint unsigned vol;
        r        = '0;
        need_new = 1'b1;
        cap      = capacity;
        wl       = w;
        if (clear) empty_bins();
        if (first_live > bins_open) first_live = bins_open;
        if (wl > cap) begin
            r.error_code = ERR_OVERSIZE;
        end else begin
            if (!forced && (last || wl + least_opening <= cap)) begin
                for (int unsigned i = first_live; i < bins_open; i++) begin
                    vol = bin_fill[i];
                    if (vol + wl <= cap) begin
                        bin_fill[i] = weight_t'(vol + wl);
                        if (bin_fill[i] > peak_fill) peak_fill = bin_fill[i];
                        r.bin_index = i[IDX_W-1:0];
                        need_new = 1'b0;
                        // bin can no longer take the lightest item
                        if (!last && i == first_live && vol + wl + min_weight > cap) begin
                            first_live++;
                            retired_sum += fill_square(bin_fill[i]);
                        end
                        break;
                    end
                end
            end
            if (need_new) begin
                if (bins_open >= MAX_BINS) begin
                    r.error_code = ERR_TABLE_FULL;
                end else begin
                    r.bin_index = bins_open[IDX_W-1:0];
                    bin_fill[bins_open] = w;
                    bins_open++;
                    r.opened_bin = 1'b1;
                    if (w < least_opening) least_opening = w;
                    if (w > peak_fill) peak_fill = w;
                end
            end
        end
        r.bins_used          = count_t'(bins_open);
        r.fill_square_sum    = last ? square_total() : '0;
        r.largest_bin_volume = peak_fill;
        r.totals_valid       = last;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (placements_due.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                due = placements_due.pop_front();
                check_field("bin_index", due.bin_index, m_bin_index);
                check_field("opened_bin", due.opened_bin, m_opened_bin);
                check_field("error_code", due.error_code, m_error_code);
                check_field("bins_used", due.bins_used, m_bins_used);
                check_field("fill_square_sum", due.fill_square_sum, m_fill_square_sum);
                check_field("largest_bin_volume", due.largest_bin_volume,
                            m_largest_bin_volume);
                check_field("totals_valid", due.totals_valid, m_totals_valid);
                n_checked++;
                if (due.opened_bin) n_opened++;
                if (due.error_code != ERR_NONE) n_dropped++;
                if (due.totals_valid) n_totals++;
            end
        end
    end

    task automatic send_item(weight_t w, logic forced, logic last, logic clear);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid         <= 1'b1;
        s_item_weight   <= w;
        s_force_new_bin <= forced;
        s_last_item     <= last;
        s_clear_bins    <= clear;
        do @(posedge aclk); while (!s_ready);
        placements_due.push_back(place_item(w, forced, last, clear));
        n_sent++;
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] addr, weight_t data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (addr == REG_BIN_CAPACITY) capacity = data;
        else min_weight = data;
        @(posedge aclk);
    endtask

    task automatic pick_config();
        weight_t cap;
        weight_t minw;
        case ($urandom_range(5))
            0: cap = 20'd1;
            1: cap = 20'd1000;
            2: cap = WEIGHT_MAX;
            3: cap = weight_t'($urandom_range(5000, 2));
            default: cap = weight_t'($urandom_range(WEIGHT_MAX, 1));
        endcase
        case ($urandom_range(4))
            0: minw = '0;
            1: minw = cap / 8;
            2: minw = cap / 3;
            3: minw = weight_t'($urandom_range(cap));
            default: minw = WEIGHT_MAX;
        endcase
        write_reg(REG_BIN_CAPACITY, cap);
        write_reg(REG_MIN_ITEM_WEIGHT, minw);
        n_settings++;
    endtask

    function automatic weight_t pick_weight();
        int unsigned cap;
        cap = capacity;
        case ($urandom_range(9))
            0, 1, 2: return weight_t'($urandom_range(cap / 6));
            3, 4:    return weight_t'($urandom_range(cap / 2));
            5, 6:    return weight_t'($urandom_range(cap));
            7:       return capacity;
            8:       return (cap < WEIGHT_MAX) ? weight_t'($urandom_range(WEIGHT_MAX, cap + 1))
                                               : WEIGHT_MAX;
            default: return weight_t'($urandom);
        endcase
    endfunction

    task automatic test_defaults_after_reset();
        send_item(20'd0, 1'b0, 1'b0, 1'b1);
        send_item(20'd1000, 1'b0, 1'b0, 1'b0);
        send_item(20'd1001, 1'b0, 1'b0, 1'b0);
        send_item(WEIGHT_MAX, 1'b0, 1'b0, 1'b0);
        send_item(20'd400, 1'b1, 1'b0, 1'b0);
        send_item(20'd700, 1'b0, 1'b0, 1'b0);
        send_item(20'd300, 1'b0, 1'b0, 1'b0);
        // dropped last request still reports totals
        send_item(WEIGHT_MAX, 1'b0, 1'b1, 1'b0);
        wait_for_idle();
    endtask

    task automatic test_bin_retirement();
        write_reg(REG_BIN_CAPACITY, 20'd1000);
        write_reg(REG_MIN_ITEM_WEIGHT, 20'd100);
        send_item(20'd600, 1'b0, 1'b0, 1'b1);
        send_item(20'd350, 1'b0, 1'b0, 1'b0);
        send_item(20'd500, 1'b0, 1'b0, 1'b0);
        send_item(20'd501, 1'b0, 1'b0, 1'b0);
        send_item(20'd50, 1'b0, 1'b1, 1'b0);
        wait_for_idle();
    endtask

    task automatic test_capacity_rewrite();
        // new capacity reaches the least opening volume only at the next clear
        write_reg(REG_BIN_CAPACITY, WEIGHT_MAX);
        send_item(20'd2000, 1'b0, 1'b0, 1'b0);
        send_item(WEIGHT_MAX, 1'b0, 1'b0, 1'b1);
        wait_for_idle();
        write_reg(REG_BIN_CAPACITY, 20'd1);
        write_reg(REG_MIN_ITEM_WEIGHT, WEIGHT_MAX);
        send_item(20'd1, 1'b0, 1'b0, 1'b1);
        send_item(20'd1, 1'b0, 1'b0, 1'b0);
        send_item(20'd0, 1'b0, 1'b0, 1'b0);
        send_item(20'd2, 1'b0, 1'b0, 1'b0);
        send_item(20'd0, 1'b1, 1'b1, 1'b0);
        wait_for_idle();
    endtask

    task automatic test_full_table();
        write_reg(REG_BIN_CAPACITY, WEIGHT_MAX);
        write_reg(REG_MIN_ITEM_WEIGHT, '0);
        for (int i = 0; i < MAX_BINS; i++) begin
            send_item(WEIGHT_MAX, 1'b1, 1'b0, i == 0);
        end
        send_item(WEIGHT_MAX, 1'b1, 1'b0, 1'b0);
        send_item(20'd5, 1'b0, 1'b0, 1'b0);
        send_item(20'd0, 1'b0, 1'b0, 1'b0);
        send_item(20'd1, 1'b0, 1'b1, 1'b0);
        wait_for_idle();
    endtask

    task automatic test_random_traffic(int unsigned n_items, int unsigned send_pct,
                                       int unsigned stall);
        int unsigned sent;
        int unsigned inst;
        int unsigned length;
        logic        clr;
        logic        lst;
        sender_idle_pct = send_pct;
        stall_pct       = stall;
        sent = 0;
        inst = 0;
        while (sent < n_items) begin
            if (inst % 6 == 0) begin
                wait_for_idle();
                pick_config();
            end
            length = $urandom_range(24, 1);
            for (int unsigned k = 0; k < length; k++) begin
                clr = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
                lst = (k == length - 1) ? ($urandom_range(9) != 0)
                                        : ($urandom_range(49) == 0);
                // keep scans short
                if (bins_open > 150) clr = 1'b1;
                send_item(pick_weight(), $urandom_range(6) == 0, lst, clr);
            end
            sent += length;
            inst++;
        end
        wait_for_idle();
    endtask

    initial begin
        capacity   = CAP_RESET;
        min_weight = '0;
        empty_bins();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_defaults_after_reset();
        test_bin_retirement();
        test_capacity_rewrite();
        test_full_table();
        test_random_traffic(70, 0, 0);
        test_random_traffic(70, 88, 0);
        test_random_traffic(70, 0, 88);
        test_random_traffic(70, 31, 31);

        sender_idle_pct = 0;
        stall_pct       = 0;
        repeat (40) @(posedge aclk);

        $display("checked %0d of %0d requests: %0d opened a bin, %0d dropped, %0d with totals",
                 n_checked, n_sent, n_opened, n_dropped, n_totals);
        $display("%0d random register settings plus directed extremes and a full bin table",
                 n_settings);
        if (mismatches == 0 && placements_due.size() == 0 && n_checked == n_sent) begin
            $display("first_fit_bin_packer test passed");
        end else begin
            $display("first_fit_bin_packer test failed");
        end
        $finish;
    end

endmodule

// ----- first_fit_bin_packer.f -----
+incdir+design
design/ffbp_pkg.sv
design/ffbp_ram.sv
design/ffbp_sqacc.sv
design/first_fit_bin_packer.sv
design/ffbp_checker.sv
tb/first_fit_bin_packer_test.sv
